// ===== hw/rtl/sha_pkg.sv =====
// Package for the SHA-256 stream hasher: constants, types and a rotate function.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // Datapath byte-write source
    typedef enum logic [1:0] {
        BSEL_DATA = 2'd0,
        BSEL_MARK = 2'd1,
        BSEL_ZERO = 2'd2
    } t_bsel;

    // Commands from controller to datapath
    typedef struct packed {
        logic       put_byte;   // write one byte at the fill position
        t_bsel      bsel;
        logic       add_len;    // count 8 message bits
        logic       put_len;    // write bit length into words 14 and 15
        logic       load_vars;  // a..h from chain
        logic       do_round;   // one round at the round counter
        logic       add_chain;  // chain += a..h
        logic       clr_msg;    // chain to initial values, length and fill to zero
        logic       clr_fill;
        logic       out_load;   // capture digest word at output index
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic       block_full;  // fill count reached 64
        logic [6:0] fill;
        logic       last_round;  // round counter is 63
    } t_sts;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha_datapath.sv =====
// SHA-256 datapath: block buffer, round logic, chaining values and length.
`timescale 1ns / 1ps
`default_nettype none
module sha_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sha_pkg::t_cmd i_cmd,
    input  wire logic [7:0]    i_byte,
    input  wire logic [2:0]    i_out_idx,
    output sha_pkg::t_sts      o_sts,
    output logic [31:0]        o_word
);

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [63:0] r_len;
    logic [6:0]  r_fill;
    logic [5:0]  r_rnd;
    logic [31:0] r_word;

    logic [7:0]  w_b;
    logic [3:0]  w_idx;
    logic [4:0]  w_sh;
    logic [31:0] w_wi, w_x2, w_x15, w_new;
    logic [31:0] w_t1, w_t2;

    // Byte source and position
    always_comb begin
        case (i_cmd.bsel)
            sha_pkg::BSEL_DATA: w_b = i_byte;
            sha_pkg::BSEL_MARK: w_b = sha_pkg::PAD_MARK;
            default:            w_b = 8'h00;
        endcase
        w_idx = r_fill[5:2];
        w_sh  = 5'd24 - {r_fill[1:0], 3'b000};
    end

    // Schedule expansion and round functions; the schedule is a 16-word window
    always_comb begin
        w_x2  = r_w[r_rnd[3:0] - 4'd2];
        w_x15 = r_w[r_rnd[3:0] - 4'd15];
        w_new = r_w[r_rnd[3:0]]
              + (sha_pkg::rotr(w_x2, 17) ^ sha_pkg::rotr(w_x2, 19) ^ (w_x2 >> 10))
              + r_w[r_rnd[3:0] - 4'd7]
              + (sha_pkg::rotr(w_x15, 7) ^ sha_pkg::rotr(w_x15, 18) ^ (w_x15 >> 3));
        w_wi = (r_rnd >= 6'd16) ? w_new : r_w[r_rnd[3:0]];
        w_t1 = r_v[7] + (sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11)
               ^ sha_pkg::rotr(r_v[4], 25))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + sha_pkg::K_TAB[r_rnd] + w_wi;
        w_t2 = (sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13)
               ^ sha_pkg::rotr(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Payload: block buffer and working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.put_byte) begin
            r_w[w_idx] <= (r_w[w_idx] & ~(32'hff << w_sh)) | ({24'h0, w_b} << w_sh);
        end
        if (i_cmd.put_len) begin
            r_w[14] <= r_len[63:32];
            r_w[15] <= r_len[31:0];
        end
        if (i_cmd.do_round) begin
            r_w[r_rnd[3:0]] <= w_wi;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end else if (i_cmd.load_vars) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end
        if (i_cmd.out_load) r_word <= r_h[i_out_idx];
    end

    // Control state: chain, length, fill count, round counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_msg) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::H_INIT[i];
            r_len  <= '0;
            r_fill <= '0;
            r_rnd  <= '0;
        end else begin
            if (i_cmd.add_chain) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cmd.add_len) r_len <= r_len + 64'd8;
            if (i_cmd.clr_fill) r_fill <= '0;
            else if (i_cmd.put_byte) r_fill <= r_fill + 7'd1;
            if (i_cmd.do_round) r_rnd <= r_rnd + 6'd1;
        end
    end

    assign o_sts.block_full = r_fill[6];
    assign o_sts.fill       = r_fill;
    assign o_sts.last_round = (r_rnd == 6'd63);
    assign o_word           = r_word;

endmodule
`default_nettype wire

// ===== hw/rtl/sha_ctrl.sv =====
// SHA-256 controller: input handshake, padding sequence, rounds and digest output.
`timescale 1ns / 1ps
`default_nettype none
module sha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_present,
    input  wire logic          i_end,
    output logic               o_in_ready,
    input  wire sha_pkg::t_sts i_sts,
    output sha_pkg::t_cmd      o_cmd,
    output logic [2:0]         o_out_idx,
    output logic               o_out_valid,
    input  wire logic          i_out_ready
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHK   = 9'b000000010,
        S_MARK  = 9'b000000100,
        S_ZERO  = 9'b000001000,
        S_LEN   = 9'b000010000,
        S_LOAD  = 9'b000100000,
        S_ROUND = 9'b001000000,
        S_ADD   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic       r_end, n_end;     // message end pending after the current block
    logic       r_final, n_final; // current compression is the last one
    logic [2:0] r_idx, n_idx;
    logic       r_ov, n_ov;
    logic       r_first, n_first; // first output word not yet loaded
    logic       r_wasPad, n_wasPad;
    logic       w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_end   = r_end;
        n_final = r_final;
        n_idx   = r_idx;
        n_ov    = r_ov;
        n_first = r_first;
        o_cmd   = '0;
        o_cmd.bsel = sha_pkg::BSEL_DATA;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.put_byte = i_present;
                    o_cmd.add_len  = i_present;
                    n_end = i_end;
                    if (i_present || i_end) n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.block_full) begin
                    o_cmd.clr_fill = 1'b1;
                    n_final = 1'b0;
                    n_state = S_LOAD;
                end else if (r_end) begin
                    n_state = S_MARK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MARK: begin
                o_cmd.put_byte = 1'b1;
                o_cmd.bsel     = sha_pkg::BSEL_MARK;
                n_end   = 1'b0;
                n_state = S_ZERO;
            end
            S_ZERO: begin
                // zero to the end of the block on spill, else up to the length
                if (i_sts.fill > {1'b0, sha_pkg::LEN_POS} && !i_sts.block_full) begin
                    o_cmd.put_byte = 1'b1;
                    o_cmd.bsel     = sha_pkg::BSEL_ZERO;
                end else if (i_sts.block_full) begin
                    o_cmd.clr_fill = 1'b1;
                    n_final = 1'b0;
                    n_state = S_LOAD;
                end else if (i_sts.fill != {1'b0, sha_pkg::LEN_POS}) begin
                    o_cmd.put_byte = 1'b1;
                    o_cmd.bsel     = sha_pkg::BSEL_ZERO;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.put_len  = 1'b1;
                o_cmd.clr_fill = 1'b1;
                n_final = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_vars = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.do_round = 1'b1;
                if (i_sts.last_round) n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.add_chain = 1'b1;
                if (r_final) begin
                    n_idx   = '0;
                    n_first = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.fill != '0 || r_end) begin
                    // spill block done: write the mark if still pending, else continue with zeros
                    n_state = r_end ? S_MARK : S_ZERO;
                end else begin
                    n_state = S_ZERO;
                end
                if (!r_final && !r_end && i_sts.fill == '0) n_state = S_ZERO;
                if (!r_final && !r_end && !r_wasPad) n_state = S_IDLE;
            end
            S_OUT: begin
                if (r_first || (r_ov && i_out_ready) || !r_ov) begin
                    if (r_first || !r_ov || r_idx != 3'd7) begin
                        o_cmd.out_load = 1'b1;
                        n_ov    = 1'b1;
                        if (!r_first) n_idx = r_idx + 3'd1;
                        n_first = 1'b0;
                    end else begin
                        n_ov    = 1'b0;
                        o_cmd.clr_msg = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // whether the running compression belongs to the padding sequence
    always_comb begin
        n_wasPad = r_wasPad;
        if (r_state == S_MARK) n_wasPad = 1'b1;
        if (o_cmd.clr_msg) n_wasPad = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_end    <= 1'b0;
            r_final  <= 1'b0;
            r_idx    <= '0;
            r_ov     <= 1'b0;
            r_first  <= 1'b0;
            r_wasPad <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_end    <= n_end;
            r_final  <= n_final;
            r_idx    <= n_idx;
            r_ov     <= n_ov;
            r_first  <= n_first;
            r_wasPad <= n_wasPad;
        end
    end

    assign o_out_idx   = n_idx;
    assign o_out_valid = r_ov;

    // Output only while emitting the digest
    a_ov_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_state == S_OUT) else $error("output valid outside digest state");
    // Input accepted only when idle
    a_acc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> r_state == S_IDLE) else $error("input taken while busy");
    // A stalled output word holds its index
    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_out_ready |=> r_idx == $past(r_idx)) else $error("index moved");

endmodule
`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: controller plus datapath.
//
// Input channel (s_axis): one beat per message byte. tdata[7:0] is the byte,
// tuser flags that the byte is present (0 allows an empty message or a bare
// finish), tlast marks the final beat of a message.
// Output channel (m_axis): eight beats per message, the digest words H0 first.
// tdata[31:0] is the word, tuser[2:0] its index, tlast flags the eighth word.
// Each byte beat is written in S_IDLE and checked in S_CHK; every 64th byte adds
// a compression (load, 64 rounds through one round unit, chain add).
// The final beat runs the padding (mark, zero bytes, length) and one or two
// compressions, then gives the digest words one per cycle while not stalled.
// The block takes one beat at a time; it accepts no input while a digest is
// being delivered. A stalled receiver holds the current word in place.
// Reset loads the initial hash values and clears length and fill count.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] byte_present
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // final_word
);

    sha_pkg::t_cmd w_cmd;
    sha_pkg::t_sts w_sts;
    logic [2:0]    w_idx;
    logic [2:0]    r_idx;

    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_present   (s_axis_tuser),
        .i_end       (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_out_idx   (w_idx),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    sha_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_byte    (s_axis_tdata),
        .i_out_idx (w_idx),
        .o_sts     (w_sts),
        .o_word    (m_axis_tdata)
    );

    // index of the word held in the output register
    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) r_idx <= w_idx;
    end

    assign m_axis_tuser = r_idx;
    assign m_axis_tlast = (r_idx == 3'd7);

endmodule
`default_nettype wire
